### rtl/core/ohash_pkg.sv
// Shared types and constants for the open addressing hash table.
`default_nettype none
package ohash_pkg;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        MODE_GET = 2'd0,
        MODE_SET = 2'd1,
        MODE_DEL = 2'd2,
        MODE_BAD = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_USED  = 2'd1,
        SL_TOMB  = 2'd2,
        SL_RSVD  = 2'd3
    } t_slot;
endpackage
`default_nettype wire

### rtl/core/ohash_front.sv
// Front end: key masking, length clamp and serial FNV-1a hash, one byte per cycle.
`default_nettype none
module ohash_front #(
    parameter int KEY_BYTES_MAX = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_key,
    input  wire logic [3:0]  i_len,
    input  wire logic [63:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_mode,
    output logic [63:0]      o_key,
    output logic [3:0]       o_len,
    output logic [63:0]      o_value,
    output logic [31:0]      o_hash
);
    import ohash_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_OUT  = 3'b100
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [1:0]  r_mode;
    logic [63:0] r_key;
    logic [3:0]  r_len;
    logic [63:0] r_value;
    logic [31:0] r_hash;
    logic [3:0]  r_idx;
    logic [3:0]  w_len;
    logic [63:0] w_mask;
    logic [31:0] w_mix;

    always_comb begin
        w_len = (i_len > 4'(KEY_BYTES_MAX)) ? 4'(KEY_BYTES_MAX) : i_len;
        for (int b = 0; b < 8; b++) begin
            w_mask[b*8 +: 8] = (4'(b) < w_len) ? 8'hFF : 8'h00;
        end
        w_mix = (r_hash ^ {24'd0, r_key[{r_idx[2:0], 3'b000} +: 8]}) * FNV_PRIME;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = (w_len == 4'd0) ? F_OUT : F_HASH;
            F_HASH: if (r_idx + 4'd1 == r_len) n_state = F_OUT;
            F_OUT:  if (i_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == F_IDLE && i_valid) begin
            r_mode  <= i_mode;
            r_key   <= i_key & w_mask;
            r_len   <= w_len;
            r_value <= i_value;
            r_hash  <= FNV_BASIS;
            r_idx   <= 4'd0;
        end else if (r_state == F_HASH) begin
            r_hash <= w_mix;
            r_idx  <= r_idx + 4'd1;
        end
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_valid = (r_state == F_OUT);
    assign o_mode  = r_mode;
    assign o_key   = r_key;
    assign o_len   = r_len;
    assign o_value = r_value;
    assign o_hash  = r_hash;
endmodule
`default_nettype wire

### rtl/core/ohash_queue.sv
// Two-entry queue between the hash front end and the probe engine.
`default_nettype none
module ohash_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### rtl/core/ohash_back.sv
// Back end: slot memories, linear probe sequencer and result register.
`default_nettype none
module ohash_back #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [8:0]  i_max_entries,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_key,
    input  wire logic [3:0]  i_len,
    input  wire logic [63:0] i_value,
    input  wire logic [31:0] i_hash,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic             o_was_new,
    output logic [31:0]      o_read_value
);
    import ohash_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [6:0] {
        B_CLEAR = 7'b0000001,
        B_IDLE  = 7'b0000010,
        B_READ  = 7'b0000100,
        B_CHECK = 7'b0001000,
        B_VREAD = 7'b0010000,
        B_DONE  = 7'b0100000,
        B_OUT   = 7'b1000000
    } t_bstate;

    t_bstate         r_state;
    logic [1:0]      m_status [SLOTS];
    logic [63:0]     m_key    [SLOTS];
    logic [3:0]      m_len    [SLOTS];
    logic [VALUE_BITS-1:0] m_value [SLOTS];

    logic [1:0]      r_st_rd;
    logic [63:0]     r_key_rd;
    logic [3:0]      r_len_rd;
    logic [VALUE_BITS-1:0] r_val_rd;

    logic [1:0]      r_mode;
    logic [63:0]     r_key;
    logic [3:0]      r_len;
    logic [VALUE_BITS-1:0] r_value;
    logic [AW-1:0]   r_idx;
    logic [CW-1:0]   r_n;
    logic            r_tomb_seen;
    logic [AW-1:0]   r_tomb;
    logic            r_found;
    logic            r_have_free;
    logic [AW-1:0]   r_slot;
    logic [8:0]      r_count;
    logic [1:0]      r_status;
    logic            r_was_new;
    logic [31:0]     r_rd;
    logic [AW-1:0]   r_clr;
    logic            w_last;

    assign w_last = (r_n == CW'(SLOTS - 1));
    assign o_ready = (r_state == B_IDLE);
    assign o_valid = (r_state == B_OUT);
    assign o_status = r_status;
    assign o_was_new = r_was_new;
    assign o_read_value = r_rd;

    always_ff @(posedge i_clk) begin
        r_st_rd  <= m_status[r_idx];
        r_key_rd <= m_key[r_idx];
        r_len_rd <= m_len[r_idx];
        r_val_rd <= m_value[r_slot];
        if (r_state == B_CLEAR) m_status[r_clr] <= SL_EMPTY;
        if (r_state == B_DONE) begin
            if (r_mode == MODE_SET && r_found) begin
                m_value[r_slot] <= r_value;
            end else if (r_mode == MODE_SET && r_have_free
                         && r_count < i_max_entries) begin
                m_status[r_slot] <= SL_USED;
                m_key[r_slot]    <= r_key;
                m_len[r_slot]    <= r_len;
                m_value[r_slot]  <= r_value;
            end else if (r_mode == MODE_DEL && r_found) begin
                m_status[r_slot] <= SL_TOMB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_count <= 9'd0;
        end else begin
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(SLOTS - 1)) r_state <= B_IDLE;
                end
                B_IDLE: if (i_valid) begin
                    r_mode      <= i_mode;
                    r_key       <= i_key;
                    r_len       <= i_len;
                    r_value     <= i_value[VALUE_BITS-1:0];
                    r_idx       <= i_hash[AW-1:0];
                    r_n         <= '0;
                    r_tomb_seen <= 1'b0;
                    r_found     <= 1'b0;
                    r_have_free <= 1'b0;
                    r_state     <= (i_mode == MODE_BAD) ? B_DONE : B_READ;
                end
                B_READ: r_state <= B_CHECK;
                B_CHECK: begin
                    if (r_st_rd == SL_EMPTY) begin
                        r_have_free <= 1'b1;
                        r_slot      <= r_tomb_seen ? r_tomb : r_idx;
                        r_state     <= B_DONE;
                    end else if (r_st_rd == SL_USED && r_len_rd == r_len
                                 && r_key_rd == r_key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx;
                        r_state <= B_VREAD;
                    end else begin
                        if (r_st_rd != SL_USED && !r_tomb_seen) begin
                            r_tomb_seen <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        if (w_last) begin
                            r_have_free <= r_tomb_seen || (r_st_rd != SL_USED);
                            r_slot      <= r_tomb_seen ? r_tomb : r_idx;
                            r_state     <= B_DONE;
                        end else begin
                            r_idx   <= (r_idx == AW'(SLOTS - 1)) ? '0 : r_idx + AW'(1);
                            r_n     <= r_n + CW'(1);
                            r_state <= B_READ;
                        end
                    end
                end
                B_VREAD: r_state <= B_DONE;
                B_DONE: begin
                    case (r_mode)
                        MODE_GET: begin
                            r_was_new <= 1'b0;
                            r_status  <= r_found ? ST_OK : ST_MISSING;
                            r_rd      <= r_found ? 32'(r_val_rd) : '0;
                        end
                        MODE_SET: begin
                            r_rd <= '0;
                            if (r_found) begin
                                r_status  <= ST_OK;
                                r_was_new <= 1'b0;
                            end else if (r_have_free && r_count < i_max_entries) begin
                                r_status  <= ST_OK;
                                r_was_new <= 1'b1;
                                r_count   <= r_count + 9'd1;
                            end else begin
                                r_status  <= ST_FULL;
                                r_was_new <= 1'b0;
                            end
                        end
                        MODE_DEL: begin
                            r_was_new <= 1'b0;
                            r_rd      <= '0;
                            if (r_found) begin
                                r_status <= ST_OK;
                                if (r_count != 9'd0) r_count <= r_count - 9'd1;
                            end else begin
                                r_status <= ST_MISSING;
                            end
                        end
                        default: begin
                            r_status  <= ST_MISSING;
                            r_was_new <= 1'b0;
                            r_rd      <= '0;
                        end
                    endcase
                    r_state <= B_OUT;
                end
                B_OUT: if (i_ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/open_addressing_hash_table.sv
// Top level of the open addressing hash table.
`default_nettype none
// Key/value table with linear probing and tombstones over SLOTS slots (a power
// of two). A request is hashed with FNV-1a, one key byte per cycle, passes a
// two-entry queue, then the probe engine reads one slot at a time from the slot
// memory until it meets an empty slot or the key; it finishes with the update
// and the result. The worst case walks all SLOTS slots. After reset a clearing
// pass marks every slot empty before the first request is probed.
module open_addressing_hash_table #(
    parameter int SLOTS         = 256,
    parameter int KEY_BYTES_MAX = 8,
    parameter int VALUE_BITS    = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [8:0]   i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[1:0], key_bytes[65:2], key_length[69:66], new_value[101:70], zero
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], was_new[2], read_value[34:3], zero
    output logic [39:0]       m_axis_tdata
);
    import ohash_pkg::*;

    localparam int QW = 2 + 64 + 4 + 64 + 32;

    logic [8:0]    r_max_entries;
    logic          w_fv, w_fr, w_bv, w_br;
    logic [1:0]    w_mode;
    logic [63:0]   w_key, w_val;
    logic [3:0]    w_len;
    logic [31:0]   w_hash;
    logic [QW-1:0] w_qd;
    logic [1:0]    w_status;
    logic          w_new;
    logic [31:0]   w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 9'd192;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    ohash_front #(.KEY_BYTES_MAX(KEY_BYTES_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tdata[1:0]), .i_key(s_axis_tdata[65:2]),
        .i_len(s_axis_tdata[69:66]), .i_value({32'd0, s_axis_tdata[101:70]}),
        .o_valid(w_fv), .i_ready(w_fr),
        .o_mode(w_mode), .o_key(w_key), .o_len(w_len), .o_value(w_val), .o_hash(w_hash)
    );

    logic [1:0]  q_mode;
    logic [63:0] q_key, q_val;
    logic [3:0]  q_len;
    logic [31:0] q_hash;

    ohash_queue #(.WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr),
        .i_data({w_mode, w_key, w_len, w_val, w_hash}),
        .o_valid(w_bv), .i_ready(w_br), .o_data(w_qd)
    );
    assign {q_mode, q_key, q_len, q_val, q_hash} = w_qd;

    ohash_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_entries(r_max_entries),
        .i_valid(w_bv), .o_ready(w_br),
        .i_mode(q_mode), .i_key(q_key), .i_len(q_len), .i_value(q_val), .i_hash(q_hash),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_was_new(w_new), .o_read_value(w_rd)
    );

    assign m_axis_tdata = {5'd0, w_rd, w_new, w_status};
endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for the open addressing hash table: scoreboard class plus driver tasks.
import ohash_pkg::*;

class hash_scoreboard;
    logic [1:0]  slot_state [256];
    logic [63:0] slot_key [256];
    logic [3:0]  slot_len [256];
    logic [31:0] slot_val [256];
    int unsigned live_count;
    int unsigned limit;
    logic [34:0] pending_q [$];
    int          err_count;

    function new();
        foreach (slot_state[i]) slot_state[i] = SL_EMPTY;
        live_count = 0;
        limit = 192;
        err_count = 0;
    endfunction

    function logic [31:0] fnv_hash(logic [63:0] key, int unsigned len);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            h = (h ^ {24'd0, key[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    // Notes an accepted request and queues the response it must produce.
    function void note_request(logic [103:0] data);
        t_mode       op;
        logic [63:0] key;
        int unsigned len;
        logic [31:0] val;
        logic [7:0]  idx;
        logic [7:0]  hit;
        logic [7:0]  tomb;
        logic [7:0]  free_slot;
        bit          tomb_seen;
        bit          have_free;
        bit          found;
        t_status     st;
        bit          fresh;
        logic [31:0] rd;
        op = t_mode'(data[1:0]);
        len = data[69:66];
        val = data[101:70];
        if (len > 8) len = 8;
        key = data[65:2];
        for (int b = 0; b < 8; b++) if (b >= len) key[8*b +: 8] = 8'd0;
        st = ST_MISSING;
        fresh = 0;
        rd = '0;
        found = 0;
        tomb_seen = 0;
        have_free = 0;
        hit = 0;
        tomb = 0;
        free_slot = 0;
        if (op != MODE_BAD) begin
            idx = 8'(fnv_hash(key, len) % 256);
            for (int n = 0; n < 256; n++) begin
                if (slot_state[idx] == SL_EMPTY) begin
                    free_slot = tomb_seen ? tomb : idx;
                    have_free = 1;
                    break;
                end
                if (slot_state[idx] == SL_TOMB) begin
                    if (!tomb_seen) begin
                        tomb_seen = 1;
                        tomb = idx;
                    end
                end else if (slot_len[idx] == len && slot_key[idx] == key) begin
                    hit = idx;
                    found = 1;
                    break;
                end
                idx = idx + 8'd1;
            end
            if (!found && !have_free && tomb_seen) begin
                free_slot = tomb;
                have_free = 1;
            end
            case (op)
                MODE_GET: begin
                    if (found) begin
                        st = ST_OK;
                        rd = slot_val[hit];
                    end
                end
                MODE_SET: begin
                    if (found) begin
                        slot_val[hit] = val;
                        st = ST_OK;
                    end else if (live_count >= limit || !have_free) begin
                        st = ST_FULL;
                    end else begin
                        slot_state[free_slot] = SL_USED;
                        slot_key[free_slot] = key;
                        slot_len[free_slot] = 4'(len);
                        slot_val[free_slot] = val;
                        live_count = (live_count + 1) & 9'h1FF;
                        st = ST_OK;
                        fresh = 1;
                    end
                end
                default: begin
                    if (found) begin
                        slot_state[hit] = SL_TOMB;
                        if (live_count > 0) live_count--;
                        st = ST_OK;
                    end
                end
            endcase
        end
        pending_q.push_back({rd, fresh, st});
    endfunction

    function void check_response(logic [39:0] data);
        logic [34:0] exp_r;
        if (pending_q.size() == 0) begin
            report("unexpected response", data[34:0], '0);
            return;
        end
        exp_r = pending_q.pop_front();
        if (data[1:0] !== exp_r[1:0])
            report("status", 35'(data[1:0]), 35'(exp_r[1:0]));
        if (data[2] !== exp_r[2])
            report("was_new", 35'(data[2]), 35'(exp_r[2]));
        if (data[34:3] !== exp_r[34:3])
            report("read_value", 35'(data[34:3]), 35'(exp_r[34:3]));
    endfunction

    function void report(string what, logic [34:0] got, logic [34:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endfunction
endclass

module tb_top;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [8:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [39:0]  m_axis_tdata;
    hash_scoreboard sb;
    longint       cycle_count = 0;
    bit           out_fast = 0;
    int unsigned  sink_hold = 0;
    logic [63:0]  key_pool [16];
    logic [3:0]   len_pool [16];

    open_addressing_hash_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("status: fail");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
    end

    function int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sink stall pattern.
    always @(negedge i_clk) begin
        if (out_fast) begin
            m_axis_tready <= 1;
        end else if (sink_hold != 0) begin
            m_axis_tready <= 0;
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1;
        end else begin
            m_axis_tready <= 0;
            sink_hold <= gap_len();
        end
    end

    task automatic send_request(t_mode op, logic [63:0] key, logic [3:0] len, logic [31:0] val);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata <= {2'b00, val, len, key, op};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request({2'b00, val, len, key, op});
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        sb.limit = v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        return k;
    endfunction

    task automatic random_phase(int n, int keyspace);
        int unsigned r;
        int unsigned p;
        t_mode op;
        logic [63:0] k;
        logic [3:0] l;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? MODE_SET : (r < 75) ? MODE_GET : (r < 97) ? MODE_DEL : MODE_BAD;
            if ($urandom_range(0, 9) < 7) begin
                p = $urandom_range(0, keyspace - 1) % 16;
                k = key_pool[p];
                l = len_pool[p];
                if ($urandom_range(0, 3) == 0) k = k ^ ({$urandom, $urandom} << (8 * l));
            end else begin
                k = rand_key();
                l = 4'($urandom_range(0, 15));
            end
            send_request(op, k, l, $urandom);
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = 4'($urandom_range(1, 8));
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        write_limit(9'd256);
        // Directed: extremes, all modes, tombstone reuse, odd lengths, unused mode.
        send_request(MODE_GET, 64'h0, 4'd1, 32'h0);
        send_request(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
        send_request(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_request(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h1234_5678);
        send_request(MODE_SET, 64'hFF, 4'd1, 32'hA5A5_A5A5);
        send_request(MODE_GET, 64'hAB00_00FF, 4'd1, 32'h0);
        send_request(MODE_SET, 64'h0, 4'd0, 32'h11);
        send_request(MODE_GET, 64'h77, 4'd0, 32'h0);
        send_request(MODE_SET, 64'h0102_0304_0506_0708, 4'd15, 32'h22);
        send_request(MODE_GET, 64'h0102_0304_0506_0708, 4'd8, 32'h0);
        send_request(MODE_DEL, 64'hFF, 4'd1, 32'h0);
        send_request(MODE_DEL, 64'hFF, 4'd1, 32'h0);
        send_request(MODE_GET, 64'hFF, 4'd1, 32'h0);
        send_request(MODE_SET, 64'hFF, 4'd1, 32'h5A5A_5A5A);
        send_request(MODE_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
        send_request(MODE_GET, 64'h5555_5555_5555_5555, 4'd7, 32'h0);
        drain();
        write_limit(9'd0);
        send_request(MODE_SET, 64'h1234, 4'd2, 32'h1);
        send_request(MODE_SET, 64'h0, 4'd0, 32'h9);
        drain();
        write_limit(9'd1);
        for (int i = 0; i < 4; i++) random_phase(25, 16);
        drain();
        write_limit(9'd511);
        out_fast = 1;
        random_phase(150, 16);
        out_fast = 0;
        // Fill the table toward the slot limit with fresh keys.
        for (int i = 0; i < 280; i++)
            send_request(MODE_SET, rand_key(), 4'($urandom_range(1, 8)), $urandom);
        drain();
        random_phase(150, 16);
        drain();
        write_limit(9'd192);
        random_phase(200, 8);
        drain();
        write_limit(9'($urandom_range(1, 256)));
        random_phase(150, 16);
        drain();
        if (sb.err_count == 0 && sb.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
